>>> design/tfdr_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// tfdr_pkg
// Shared types and constants for the threshold fan duty ramp unit: state
// codes, register indexes, duty levels and the divider request and response.
// ============================================================================
package tfdr_pkg;

   // Duty levels in 1/256 percent
   localparam logic [14:0] DUTY_FULL = 15'd25600;
   localparam logic [14:0] DUTY_HIGH = 15'd19200;
   localparam logic [14:0] DUTY_ZERO = 15'd0;

   // Item function codes
   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_TICK   = 1'b1;

   // Divider pass lengths: the step count fits in 15 bits, the delay in 32
   localparam logic [5:0] DIV_ITERS_STEPS = 6'd15;
   localparam logic [5:0] DIV_ITERS_DELAY = 6'd32;

   // Register map, one 32-bit register every four bytes
   localparam int CSR_ADDR_W = 4;

   typedef enum logic [1:0] {
      REG_LOW_THRESHOLD  = 2'd0,
      REG_HIGH_THRESHOLD = 2'd1,
      REG_RAMP_STEP      = 2'd2,
      REG_RAMP_TIME_MS   = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_STEPS,
      ST_DIV_DELAY,
      ST_EMIT
   } state_type;

   // Request to the shared divider
   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [15:0] divisor;
      logic [5:0]  iters;
   } div_req_type;

   // Answer of the shared divider
   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;

endpackage

>>> design/tfdr_if.sv
`timescale 1ns / 1ps
// ============================================================================
// tfdr_if
// Valid/ready channels of the threshold fan duty ramp unit: the request
// channel (sample or tick) and the response channel (duty update).
// ============================================================================
interface tfdr_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [15:0] sensor_value;

   modport source (output valid, output func, output sensor_value, input ready);
   modport sink   (input valid, input func, input sensor_value, output ready);
endinterface

interface tfdr_rsp_if;
   logic        valid;
   logic        ready;
   logic [14:0] duty;
   logic        final_res;

   modport source (output valid, output duty, output final_res, input ready);
   modport sink   (input valid, input duty, input final_res, output ready);
endinterface

>>> design/tfdr_div.sv
`timescale 1ns / 1ps
// ============================================================================
// tfdr_div
// Restoring divider, one quotient bit per cycle. A pass runs for the number
// of iterations given at start; the quotient sits in the low bits after.
// ============================================================================
module tfdr_div
   import tfdr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [15:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;

   logic [16:0] shifted;
   logic [16:0] trial;
   logic        fits;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      shifted = {rem_ff, quo_ff[31]};
      trial   = shifted - {1'b0, dvs_ff};
      fits    = (shifted >= {1'b0, dvs_ff});
   end

   // Load on start, else advance while iterations remain
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in = 16'd0;
         quo_in = req.dividend;
         dvs_in = req.divisor;
         cnt_in = req.iters;
      end else if (cnt_ff != 6'd0) begin
         rem_in  = fits ? trial[15:0] : shifted[15:0];
         quo_in  = {quo_ff[30:0], fits};
         cnt_in  = cnt_ff - 6'd1;
         done_in = (cnt_ff == 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 6'd0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

>>> design/threshold_fan_duty_ramp_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// threshold_fan_duty_ramp_unit
// Fan duty soft-start ramp driven by a sensor reading against two thresholds.
// ============================================================================
// A sample beat picks a target duty of 0, 75 or 100 percent (1/256 percent
// units), works out the step count and the delay per step on one shared
// bit-serial divider, and answers with the first ramp step; it is dropped
// when the ramp step is zero or above full scale. The divider runs one pass
// for the step count and, when the difference holds a whole step, a second
// for the delay. A tick beat releases the next step, or the exact target
// flagged by final_res, once the delay in ticks has run out. One response
// register parts the output side, so a new beat is taken while a finished
// response still waits.
// ============================================================================
module threshold_fan_duty_ramp_unit
   import tfdr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   tfdr_req_if.sink              req_chan,
   tfdr_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   // Configuration registers
   logic [15:0] low_thr_ff;
   logic [15:0] high_thr_ff;
   logic [15:0] ramp_step_ff;
   logic [31:0] ramp_time_ff;

   // Ramp state
   state_type   state_ff, state_in;
   logic [14:0] cur_duty_ff, cur_duty_in;
   logic [14:0] target_ff, target_in;
   logic        step_down_ff, step_down_in;
   logic [31:0] step_delay_ff, step_delay_in;
   logic [31:0] tick_cnt_ff, tick_cnt_in;
   logic        active_ff, active_in;

   // Response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [14:0] rsp_duty_ff, rsp_duty_in;
   logic        rsp_final_ff, rsp_final_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic        req_fire;
   logic        out_free;
   logic        emit;
   logic        step_ok;
   logic        is_sample;
   logic        is_tick;
   logic [14:0] smp_target;
   logic [14:0] smp_diff;
   logic [31:0] tick_next;
   logic        tick_last;
   logic [14:0] steps_q;
   logic [14:0] rel_diff;
   logic [16:0] up_sum;
   logic [14:0] rel_step;
   logic        rel_final;
   logic        csr_write;
   reg_index_type csr_index;

   // ---------------------------------------------------------------------
   // Configuration port
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign csr_index = reg_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         low_thr_ff   <= 16'd0;
         high_thr_ff  <= 16'd0;
         ramp_step_ff <= 16'd256;
         ramp_time_ff <= 32'd0;
      end else if (csr_write) begin
         case (csr_index)
            REG_LOW_THRESHOLD:  low_thr_ff   <= pwdata[15:0];
            REG_HIGH_THRESHOLD: high_thr_ff  <= pwdata[15:0];
            REG_RAMP_STEP:      ramp_step_ff <= pwdata[15:0];
            REG_RAMP_TIME_MS:   ramp_time_ff <= pwdata;
            default: ;
         endcase
      end
   end

   // Read back the addressed register
   always_comb begin
      case (csr_index)
         REG_LOW_THRESHOLD:  prdata = {16'd0, low_thr_ff};
         REG_HIGH_THRESHOLD: prdata = {16'd0, high_thr_ff};
         REG_RAMP_STEP:      prdata = {16'd0, ramp_step_ff};
         REG_RAMP_TIME_MS:   prdata = ramp_time_ff;
         default:            prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Decode of the incoming beat
   // ---------------------------------------------------------------------
   assign req_fire  = req_chan.valid & req_chan.ready;
   assign is_sample = (req_chan.func == FUNC_SAMPLE);
   assign is_tick   = (req_chan.func == FUNC_TICK);
   assign step_ok   = (ramp_step_ff != 16'd0) && (ramp_step_ff <= {1'b0, DUTY_FULL});
   assign out_free  = ~rsp_valid_ff | rsp_chan.ready;

   // Pick the target level from the thresholds
   always_comb begin
      if (req_chan.sensor_value < low_thr_ff) begin
         smp_target = DUTY_ZERO;
      end else if (req_chan.sensor_value < high_thr_ff) begin
         smp_target = DUTY_HIGH;
      end else begin
         smp_target = DUTY_FULL;
      end
      smp_diff = (smp_target > cur_duty_ff) ? (smp_target - cur_duty_ff)
                                            : (cur_duty_ff - smp_target);
   end

   assign tick_next = tick_cnt_ff + 32'd1;
   assign tick_last = (tick_next >= step_delay_ff);
   assign steps_q   = div_rsp.quotient[14:0];

   // ---------------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (is_sample && step_ok) begin
                  state_in = ST_DIV_STEPS;
               end else if (is_tick && active_ff && tick_last) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_DIV_STEPS: begin
            if (div_rsp.done) begin
               state_in = (steps_q == 15'd0) ? ST_EMIT : ST_DIV_DELAY;
            end
         end
         ST_DIV_DELAY: begin
            if (div_rsp.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer: outputs and divider requests
   // ---------------------------------------------------------------------
   always_comb begin
      req_chan.ready   = 1'b0;
      emit             = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = {smp_diff, 17'd0};
      div_req.divisor  = ramp_step_ff;
      div_req.iters    = DIV_ITERS_STEPS;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            div_req.start  = req_fire & is_sample & step_ok;
         end
         ST_DIV_STEPS: begin
            div_req.start    = div_rsp.done & (steps_q != 15'd0);
            div_req.dividend = ramp_time_ff;
            div_req.divisor  = {1'b0, steps_q};
            div_req.iters    = DIV_ITERS_DELAY;
         end
         ST_DIV_DELAY: ;
         ST_EMIT: begin
            emit = out_free;
         end
         default: ;
      endcase
   end

   tfdr_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // ---------------------------------------------------------------------
   // Release of one ramp stage: next step, clamped, or the exact target
   // ---------------------------------------------------------------------
   always_comb begin
      rel_diff  = (cur_duty_ff > target_ff) ? (cur_duty_ff - target_ff)
                                           : (target_ff - cur_duty_ff);
      rel_final = ({1'b0, rel_diff} <= ramp_step_ff);
      up_sum    = {2'b00, cur_duty_ff} + {1'b0, ramp_step_ff};
      if (step_down_ff) begin
         rel_step = ({1'b0, cur_duty_ff} <= ramp_step_ff) ? DUTY_ZERO
                  : (cur_duty_ff - ramp_step_ff[14:0]);
      end else begin
         rel_step = (up_sum > {2'b00, DUTY_FULL}) ? DUTY_FULL : up_sum[14:0];
      end
   end

   // ---------------------------------------------------------------------
   // Ramp state and response register updates
   // ---------------------------------------------------------------------
   always_comb begin
      cur_duty_in   = cur_duty_ff;
      target_in     = target_ff;
      step_down_in  = step_down_ff;
      step_delay_in = step_delay_ff;
      tick_cnt_in   = tick_cnt_ff;
      active_in     = active_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_chan.ready;
      rsp_duty_in   = rsp_duty_ff;
      rsp_final_in  = rsp_final_ff;

      // Latch the new target and direction on a valid sample; count ticks while a ramp runs
      if (state_ff == ST_IDLE && req_fire) begin
         if (is_sample && step_ok) begin
            target_in    = smp_target;
            step_down_in = ~(smp_target > cur_duty_ff);
            tick_cnt_in  = 32'd0;
         end else if (is_tick && active_ff) begin
            tick_cnt_in = tick_last ? 32'd0 : tick_next;
         end
      end

      // Store the delay per step once known
      if (state_ff == ST_DIV_STEPS && div_rsp.done && steps_q == 15'd0) begin
         step_delay_in = 32'd1;
      end
      if (state_ff == ST_DIV_DELAY && div_rsp.done) begin
         step_delay_in = (div_rsp.quotient == 32'd0) ? 32'd1 : div_rsp.quotient;
      end

      // Hand one stage to the response register
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_final_in = rel_final;
         if (rel_final) begin
            cur_duty_in = target_ff;
            rsp_duty_in = target_ff;
            active_in   = 1'b0;
         end else begin
            cur_duty_in = rel_step;
            rsp_duty_in = rel_step;
            active_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cur_duty_ff   <= 15'd0;
         target_ff     <= 15'd0;
         step_down_ff  <= 1'b0;
         step_delay_ff <= 32'd1;
         tick_cnt_ff   <= 32'd0;
         active_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_duty_ff   <= cur_duty_in;
         target_ff     <= target_in;
         step_down_ff  <= step_down_in;
         step_delay_ff <= step_delay_in;
         tick_cnt_ff   <= tick_cnt_in;
         active_ff     <= active_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_duty_ff  <= rsp_duty_in;
      rsp_final_ff <= rsp_final_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.duty      = rsp_duty_ff;
   assign rsp_chan.final_res = rsp_final_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
`ifndef SYNTH
   // Duty never leaves the 0..100 percent range
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      cur_duty_ff <= DUTY_FULL)
      else $error("current duty above full scale");

   // Delay per step is at least one tick
   a_delay_nonzero: assert property (@(posedge clock) disable iff (reset)
      step_delay_ff != 32'd0)
      else $error("step delay is zero");

   // A valid sample always starts the step count division
   a_sample_divides: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_fire && is_sample && step_ok)
         |=> (state_ff == ST_DIV_STEPS))
      else $error("sample did not start division");

   // The divider only finishes while the sequencer waits for it
   a_div_done_owned: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV_STEPS || state_ff == ST_DIV_DELAY))
      else $error("divider finished outside a division state");
`endif

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the threshold fan duty ramp unit.
// ============================================================================
// Sample and tick beats go in on the request channel. A behavioral fan-duty
// model inside the bench tracks the ramp and queues the duty beat each
// accepted item should produce. Every duty beat taken from the response
// channel is compared with the oldest queued one. The registers are
// programmed over the APB port only between phases, and each write is read
// back. Directed tests cover the threshold edges, step and ramp-time
// extremes and a long response stall; random phases follow.
// ============================================================================
module tb_top
   import tfdr_pkg::*;
();

   localparam int QUIET_LIMIT   = 4000;  // cycles with no beat or access
   localparam int SETTLE_CYCLES = 80;    // lets the longest sample finish
   localparam int LONG_HOLD     = 300;   // receiver hold-off under pressure
   localparam int PHASES        = 27;
   localparam int PHASE_ITEMS   = 60;
   localparam int QUIET_PHASES  = 3;     // last phases run without gaps

   typedef struct packed {
      logic [14:0] duty;
      logic        final_res;
   } duty_beat_type;

   logic                  clock   = 1'b0;
   logic                  reset   = 1'b1;
   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [31:0]           pwdata  = '0;
   logic [31:0]           prdata;
   logic                  pready;

   tfdr_req_if req_bus ();
   tfdr_rsp_if rsp_bus ();

   // Fan duty model: registers and ramp state
   logic [15:0]   cfg_low_thr  = 16'd0;
   logic [15:0]   cfg_high_thr = 16'd0;
   logic [15:0]   cfg_step     = 16'd256;
   logic [31:0]   cfg_ramp_ms  = 32'd0;
   logic [14:0]   fan_duty     = DUTY_ZERO;
   logic [14:0]   fan_target   = DUTY_ZERO;
   logic          ramp_down    = 1'b0;
   logic [31:0]   stage_delay  = 32'd1;
   logic [31:0]   stage_ticks  = 32'd0;
   logic          ramp_running = 1'b0;
   duty_beat_type duty_due_q[$];

   // Bench control and statistics
   logic gaps_on      = 1'b1;
   logic hold_request = 1'b0;
   int   hold_left    = 0;
   int   stall_left   = 0;
   int   quiet_cycles = 0;
   int   fail_count   = 0;
   int   samples_sent = 0;
   int   samples_ignored = 0;
   int   ticks_sent   = 0;
   int   beats_checked = 0;
   int   final_beats  = 0;
   int   reg_writes   = 0;

   threshold_fan_duty_ramp_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic note_mismatch(input string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("MISMATCH at %0t: %s", $realtime, msg);
      end
   endtask

   function automatic logic [15:0] duty_distance(input logic [14:0] a, input logic [14:0] b);
      return (a > b) ? 16'(a - b) : 16'(b - a);
   endfunction

   // Release one stage: the next step, clamped, or the exact target
   task automatic release_ramp_stage();
      int            stepped;
      duty_beat_type beat;
      if (duty_distance(fan_duty, fan_target) > cfg_step) begin
         stepped = ramp_down ? int'(fan_duty) - int'(cfg_step)
                             : int'(fan_duty) + int'(cfg_step);
         if (stepped < 0) begin
            stepped = 0;
         end else if (stepped > int'(DUTY_FULL)) begin
            stepped = int'(DUTY_FULL);
         end
         fan_duty       = 15'(stepped);
         ramp_running   = 1'b1;
         beat.final_res = 1'b0;
      end else begin
         fan_duty       = fan_target;
         ramp_running   = 1'b0;
         beat.final_res = 1'b1;
      end
      beat.duty = fan_duty;
      duty_due_q.push_back(beat);
   endtask

   // Advance the fan duty model by one accepted beat
   task automatic advance_fan_model(input logic func, input logic [15:0] reading);
      logic [31:0] whole_steps;
      logic [31:0] delay;
      if (func == FUNC_SAMPLE) begin
         samples_sent++;
         // Drop the sample on an out-of-range step
         if (cfg_step == 16'd0 || cfg_step > DUTY_FULL) begin
            samples_ignored++;
            return;
         end
         if (reading < cfg_low_thr) begin
            fan_target = DUTY_ZERO;
         end else if (reading < cfg_high_thr) begin
            fan_target = DUTY_HIGH;
         end else begin
            fan_target = DUTY_FULL;
         end
         ramp_down   = (fan_target > fan_duty) ? 1'b0 : 1'b1;
         whole_steps = 32'(duty_distance(fan_target, fan_duty)) / 32'(cfg_step);
         delay       = (whole_steps > 0) ? cfg_ramp_ms / whole_steps : 32'd0;
         if (delay < 32'd1) begin
            delay = 32'd1;
         end
         stage_delay = delay;
         stage_ticks = 32'd0;
         release_ramp_stage();
      end else begin
         ticks_sent++;
         if (!ramp_running) begin
            return;
         end
         stage_ticks++;
         if (stage_ticks < stage_delay) begin
            return;
         end
         stage_ticks = 32'd0;
         release_ramp_stage();
      end
   endtask

   function automatic logic [31:0] model_reg_value(input reg_index_type idx);
      case (idx)
         REG_LOW_THRESHOLD:  return {16'd0, cfg_low_thr};
         REG_HIGH_THRESHOLD: return {16'd0, cfg_high_thr};
         REG_RAMP_STEP:      return {16'd0, cfg_step};
         default:            return cfg_ramp_ms;
      endcase
   endfunction

   // One APB transfer: setup cycle, then access cycle until pready
   task automatic csr_access(input logic write, input reg_index_type idx,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic check_reg(input reg_index_type idx);
      logic [31:0] got;
      csr_access(1'b0, idx, 32'd0, got);
      if (got !== model_reg_value(idx)) begin
         note_mismatch($sformatf("register %s read: expected %0d, got %0d",
                                 idx.name(), model_reg_value(idx), got));
      end
   endtask

   // Write a register, update the model, read it back
   task automatic program_reg(input reg_index_type idx, input logic [31:0] value);
      logic [31:0] unused;
      csr_access(1'b1, idx, value, unused);
      reg_writes++;
      case (idx)
         REG_LOW_THRESHOLD:  cfg_low_thr  = value[15:0];
         REG_HIGH_THRESHOLD: cfg_high_thr = value[15:0];
         REG_RAMP_STEP:      cfg_step     = value[15:0];
         default:            cfg_ramp_ms  = value;
      endcase
      check_reg(idx);
   endtask

   task automatic program_all(input logic [31:0] low, input logic [31:0] high,
                              input logic [31:0] step, input logic [31:0] ramp_ms);
      program_reg(REG_LOW_THRESHOLD, low);
      program_reg(REG_HIGH_THRESHOLD, high);
      program_reg(REG_RAMP_STEP, step);
      program_reg(REG_RAMP_TIME_MS, ramp_ms);
   endtask

   // Offer one beat, with an optional gap first; return once accepted
   task automatic send_fan_beat(input logic func, input logic [15:0] reading);
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.func         <= func;
      req_bus.sensor_value <= reading;
      do @(posedge clock); while (!req_bus.ready);
      advance_fan_model(func, reading);
   endtask

   task automatic send_tick();
      send_fan_beat(FUNC_TICK, 16'($urandom));
   endtask

   // Drop valid, wait for every queued duty beat, then let the block go quiet
   task automatic drain_and_settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (duty_due_q.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_reset_values();
      check_reg(REG_LOW_THRESHOLD);
      check_reg(REG_HIGH_THRESHOLD);
      check_reg(REG_RAMP_STEP);
      check_reg(REG_RAMP_TIME_MS);
      // Tick while idle, then a ramp on the reset settings
      send_tick();
      send_fan_beat(FUNC_SAMPLE, 16'hFFFF);
      send_tick();
      drain_and_settle();
   endtask

   task automatic test_threshold_levels();
      program_all(32'd1000, 32'd5000, 32'(DUTY_FULL), 32'd3);
      send_fan_beat(FUNC_SAMPLE, 16'd999);
      send_fan_beat(FUNC_SAMPLE, 16'd1000);
      send_fan_beat(FUNC_SAMPLE, 16'd4999);
      send_fan_beat(FUNC_SAMPLE, 16'd5000);
      send_fan_beat(FUNC_SAMPLE, 16'd0);
      drain_and_settle();
      program_reg(REG_LOW_THRESHOLD, 32'hFFFF_FFFF);
      program_reg(REG_HIGH_THRESHOLD, 32'h0000_FFFF);
      send_fan_beat(FUNC_SAMPLE, 16'hFFFE);
      send_fan_beat(FUNC_SAMPLE, 16'hFFFF);
      drain_and_settle();
      program_reg(REG_LOW_THRESHOLD, 32'd0);
      send_fan_beat(FUNC_SAMPLE, 16'd0);
      drain_and_settle();
   endtask

   task automatic test_step_edges();
      // Smallest step, then change the step while the ramp runs
      program_all(32'd0, 32'd0, 32'd1, 32'd0);
      send_fan_beat(FUNC_SAMPLE, 16'hFFFF);
      send_tick();
      drain_and_settle();
      program_reg(REG_RAMP_STEP, 32'd0);
      send_tick();
      send_fan_beat(FUNC_SAMPLE, 16'h1234);
      drain_and_settle();
      program_reg(REG_RAMP_STEP, 32'(DUTY_FULL) + 32'd1);
      send_fan_beat(FUNC_SAMPLE, 16'h8000);
      send_tick();
      drain_and_settle();
      program_reg(REG_RAMP_STEP, 32'h0000_FFFF);
      send_fan_beat(FUNC_SAMPLE, 16'h7FFF);
      drain_and_settle();
   endtask

   task automatic test_ramp_time_extremes();
      // Huge per-step delay: ticks release nothing
      program_all(32'hFFFF, 32'hFFFF, 32'd1000, 32'hFFFF_FFFF);
      send_fan_beat(FUNC_SAMPLE, 16'd0);
      send_tick();
      send_tick();
      drain_and_settle();
      // Restart from the current duty with no delay
      program_reg(REG_RAMP_TIME_MS, 32'd0);
      send_fan_beat(FUNC_SAMPLE, 16'd12345);
      send_tick();
      drain_and_settle();
      // Difference holds no whole step
      program_reg(REG_RAMP_STEP, 32'(DUTY_FULL));
      program_reg(REG_RAMP_TIME_MS, 32'hFFFF_FFFF);
      send_fan_beat(FUNC_SAMPLE, 16'd1);
      drain_and_settle();
   endtask

   task automatic test_full_response_stall();
      // Full-scale target with a small step keeps the ramp running on every tick
      program_all(32'd0, 32'd0, 32'd64, 32'd0);
      gaps_on = 1'b0;
      send_fan_beat(FUNC_SAMPLE, 16'hFFFF);
      hold_request = 1'b1;
      // Keep offering ticks while the receiver holds off
      repeat (40) send_tick();
      gaps_on = 1'b1;
      drain_and_settle();
   endtask

   task automatic test_random_traffic();
      logic [31:0] low;
      logic [31:0] high;
      logic [31:0] step;
      logic [31:0] ramp_ms;
      logic [15:0] reading;
      for (int phase = 0; phase < PHASES; phase++) begin
         case ($urandom_range(0, 5))
            0:       low = 32'd0;
            1:       low = 32'hFFFF;
            default: low = $urandom_range(32'hFFFF, 0);
         endcase
         case ($urandom_range(0, 5))
            0:       high = 32'd0;
            1:       high = 32'hFFFF;
            default: high = $urandom_range(32'hFFFF, low);
         endcase
         case ($urandom_range(0, 9))
            0:       step = 32'd0;
            1:       step = $urandom_range(32'hFFFF, 32'(DUTY_FULL) + 1);
            2:       step = 32'(DUTY_FULL);
            3:       step = 32'd1;
            default: step = $urandom_range(6400, 16);
         endcase
         case ($urandom_range(0, 5))
            0:       ramp_ms = 32'd0;
            1:       ramp_ms = 32'hFFFF_FFFF;
            2:       ramp_ms = $urandom;
            default: ramp_ms = $urandom_range(400, 0);
         endcase
         // Random upper bits on the 16-bit registers must be dropped
         program_all({16'($urandom), low[15:0]}, {16'($urandom), high[15:0]},
                     {16'($urandom), step[15:0]}, ramp_ms);
         gaps_on = (phase < PHASES - QUIET_PHASES) && ($urandom_range(0, 3) != 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 4) == 0) begin
               case ($urandom_range(0, 5))
                  0:       reading = cfg_low_thr;
                  1:       reading = cfg_low_thr - 16'd1;
                  2:       reading = cfg_high_thr;
                  3:       reading = cfg_high_thr - 16'd1;
                  default: reading = 16'($urandom);
               endcase
               send_fan_beat(FUNC_SAMPLE, reading);
            end else begin
               send_tick();
            end
         end
         drain_and_settle();
      end
   endtask

   // Response side: random stall bursts, plus one long hold on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Compare each duty beat with the oldest expected one
   always @(posedge clock) begin
      duty_beat_type due;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         beats_checked++;
         if (rsp_bus.final_res) begin
            final_beats++;
         end
         if (duty_due_q.size() == 0) begin
            note_mismatch($sformatf("unexpected duty beat: duty %0d final %0b",
                                    rsp_bus.duty, rsp_bus.final_res));
         end else begin
            due = duty_due_q.pop_front();
            if (rsp_bus.duty !== due.duty) begin
               note_mismatch($sformatf("duty: expected %0d, got %0d",
                                       due.duty, rsp_bus.duty));
            end
            if (rsp_bus.final_res !== due.final_res) begin
               note_mismatch($sformatf("final_res: expected %0b, got %0b (duty %0d)",
                                       due.final_res, rsp_bus.final_res, due.duty));
            end
         end
      end
   end

   // Watchdog: end the run after a long stretch with no progress
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (psel && penable && pready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
            $display("tb_top NOT OK");
            $finish;
         end
      end
   end

   initial begin
      req_bus.valid        = 1'b0;
      req_bus.func         = FUNC_SAMPLE;
      req_bus.sensor_value = 16'd0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_threshold_levels();
      test_step_edges();
      test_ramp_time_extremes();
      test_full_response_stall();
      test_random_traffic();

      $display("covered %0d samples (%0d dropped for a bad step) and %0d ticks",
               samples_sent, samples_ignored, ticks_sent);
      $display("checked %0d duty beats (%0d final) after %0d register writes",
               beats_checked, final_beats, reg_writes);
      if (fail_count == 0 && duty_due_q.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("%0d mismatches, %0d duty beats never seen", fail_count, duty_due_q.size());
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
